@@ design/tlsd_pkg.sv @@
// Package for the two-layer shear drag unit: types, constants and block-float helpers
`default_nettype none
package tlsd_pkg;

  localparam int unsigned MantW     = 32;
  localparam int unsigned ExpW      = 10;
  localparam int unsigned SqrtSteps = 32;
  localparam int unsigned DivSteps  = 33;
  localparam int unsigned CfgIdxW   = 2;

  localparam logic [CfgIdxW-1:0] CFG_DRAG    = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_DENSITY = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_RADIUS  = 2'd2;

  localparam logic [31:0] DensityReset = 32'h0100_0000;
  localparam logic [31:0] RadiusReset  = 32'h0100_0000;

  typedef struct packed {
    logic [MantW-1:0]       m;
    logic signed [ExpW-1:0] e;
  } bfl_t;

  typedef struct packed {
    logic [31:0] h1;
    logic [31:0] h2;
    logic signed [31:0] se;
    logic signed [31:0] sn;
    logic signed [31:0] te;
    logic signed [31:0] tn;
    logic        err;
    logic        fin;
  } node_t;

  // normalise a 64-bit mantissa with exponent e
  function automatic bfl_t bf_norm(input logic [63:0] m, input logic signed [ExpW-1:0] e);
    bfl_t r;
    logic [6:0] lz;
    logic [63:0] t;
    lz = 7'd64;
    for (int i = 0; i < 64; i++) begin
      if (m[i]) lz = 7'(63 - i);
    end
    r.m = '0;
    r.e = '0;
    if (m != 64'd0) begin
      t   = m << lz;
      r.m = t[63:32];
      r.e = e + ExpW'(32) - ExpW'(lz);
    end
    return r;
  endfunction

  function automatic bfl_t bf_mul(input bfl_t a, input bfl_t b);
    logic [63:0] p;
    p = 64'(a.m) * 64'(b.m);
    if (a.m == '0 || b.m == '0) return bfl_t'('0);
    return bf_norm(p, a.e + b.e);
  endfunction

  function automatic bfl_t bf_add(input bfl_t a, input bfl_t b);
    bfl_t x;
    bfl_t y;
    logic signed [ExpW:0] d;
    logic [63:0] sm;
    if (a.m == '0) return b;
    if (b.m == '0) return a;
    if (a.e < b.e) begin
      x = b; y = a;
    end else begin
      x = a; y = b;
    end
    d  = (ExpW+1)'(x.e) - (ExpW+1)'(y.e);
    sm = (d >= 64) ? 64'd0 : (64'(y.m) >> d);
    return bf_norm(64'(x.m) + sm, x.e);
  endfunction

  function automatic logic [63:0] bf_to_q16(input bfl_t a);
    logic signed [ExpW-1:0] sh;
    sh = a.e + ExpW'(16);
    if (a.m == '0) return 64'd0;
    if (sh >= 2) return 64'h2_0000_0000;
    if (sh >= 0) return 64'(a.m) << sh;
    if (sh > -64) return 64'(a.m) >> (-sh);
    return 64'd0;
  endfunction

  function automatic logic [31:0] sat32(input logic signed [65:0] v);
    if (v > 66'sd2147483647) return 32'h7fff_ffff;
    if (v < -66'sd2147483648) return 32'h8000_0000;
    return v[31:0];
  endfunction

endpackage
`default_nettype wire

@@ design/tlsd_if.sv @@
// Valid/ready stream interface carrying one payload word
`default_nettype none
interface tlsd_if #(parameter int unsigned W = 1);
  logic         valid;
  logic         ready;
  logic [W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

@@ design/tlsd_sqrt_cell.sv @@
// One restoring step of the square root and of the factor division
`default_nettype none
module tlsd_sqrt_cell
  import tlsd_pkg::*;
(
  input  wire logic [65:0] rem_i,
  input  wire logic [32:0] root_i,
  input  wire logic [63:0] rad_i,
  output logic      [65:0] rem_o,
  output logic      [32:0] root_o,
  output logic      [63:0] rad_o,
  input  wire logic [64:0] drem_i,
  input  wire logic [63:0] dnum_i,
  input  wire logic [31:0] dden_i,
  input  wire logic [32:0] dq_i,
  output logic      [64:0] drem_o,
  output logic      [63:0] dnum_o,
  output logic      [32:0] dq_o
);
  logic [65:0] r;
  logic [65:0] t;
  logic [64:0] dr;
  always_comb begin
    r = {rem_i[63:0], rad_i[63:62]};
    t = {root_i[31:0], 2'b01};
    rad_o = rad_i << 2;
    if (r >= t) begin
      rem_o  = r - t;
      root_o = {root_i[31:0], 1'b1};
    end else begin
      rem_o  = r;
      root_o = {root_i[31:0], 1'b0};
    end
    dr = {drem_i[63:0], dnum_i[63]};
    dnum_o = dnum_i << 1;
    if (dr >= 65'(dden_i)) begin
      drem_o = dr - 65'(dden_i);
      dq_o   = {dq_i[31:0], 1'b1};
    end else begin
      drem_o = dr;
      dq_o   = {dq_i[31:0], 1'b0};
    end
  end
endmodule
`default_nettype wire

@@ design/two_layer_shear_drag.sv @@
// Top level: pipelined two-layer quadratic interface drag
// One node per cycle is accepted while the pipeline is not stalled.
// The chain of 33 root/divide cells forms the bulk of the pipeline; each cell is one
// restoring step, registered, so a node enters every cycle when not stalled.
// A stall holds the whole pipeline; the output register frees when taken.
// Synchronous active-low reset clears valid bits and restores register defaults.
`default_nettype none
module two_layer_shear_drag
  import tlsd_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst_n,
  tlsd_if.sink                     in_ch,
  tlsd_if.source                   out_ch,
  input  wire logic                cfg_we,
  input  wire logic [CfgIdxW-1:0]  cfg_idx,
  input  wire logic [31:0]         cfg_data
);
  localparam int unsigned N = DivSteps;
  localparam int unsigned L = N + 9;

  logic [31:0] drag_r, dens_r, rad_r;
  logic [L-1:0] v_r;
  logic adv;
  assign adv = !out_ch.valid || out_ch.ready || !v_r[L-1];
  assign in_ch.ready = adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      drag_r <= '0; dens_r <= DensityReset; rad_r <= RadiusReset;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        CFG_DRAG:    drag_r <= cfg_data;
        CFG_DENSITY: dens_r <= cfg_data;
        CFG_RADIUS:  rad_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  node_t nd_r [L];
  node_t nin;
  always_comb begin
    nin.h1  = in_ch.data[192:161];
    nin.h2  = in_ch.data[160:129];
    nin.se  = in_ch.data[128:97];
    nin.sn  = in_ch.data[96:65];
    nin.te  = in_ch.data[64:33];
    nin.tn  = in_ch.data[32:1];
    nin.fin = in_ch.data[0];
    nin.err = (nin.h1 == '0) || (nin.h2 == '0);
  end

  // front stages: factor chain
  bfl_t g_r, h1_r, h2_r, h11_r, h22_r, gh1_r, h12_r;
  bfl_t n1_r, n2_r, s_r, dd_r, num_r, s2_r, den_r;
  logic [63:0] sq_r;
  logic [63:0] sq1_r, sq2_r;
  logic [63:0] sq3_r, sq4_r, sq5_r;
  bfl_t num6_r, den6_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      g_r   <= bf_norm(64'(dens_r) * 64'(rad_r), -ExpW'(48));
      h1_r  <= bf_norm(64'(nin.h1), -ExpW'(16));
      h2_r  <= bf_norm(64'(nin.h2), -ExpW'(16));
      sq1_r <= 64'(nin.se) * 64'(nin.se) + 64'(nin.sn) * 64'(nin.sn);
      h11_r <= bf_mul(h1_r, h1_r);
      h22_r <= bf_mul(h2_r, h2_r);
      gh1_r <= bf_mul(g_r, h1_r);
      h12_r <= bf_mul(h1_r, h2_r);
      sq2_r <= sq1_r;
      n1_r  <= bf_mul(h11_r, bf_norm(64'(nd_r[1].h1), -ExpW'(16)));
      n2_r  <= bf_mul(h22_r, bf_norm(64'(nd_r[1].h2), -ExpW'(16)));
      s_r   <= bf_add(gh1_r, bf_norm(64'(nd_r[1].h2), -ExpW'(16)));
      dd_r  <= h12_r;
      sq3_r <= sq2_r;
      num_r <= bf_add(bf_mul(g_r, n1_r), n2_r);
      s2_r  <= s_r;
      den_r <= bf_mul(dd_r, s_r);
      sq4_r <= sq3_r;
      num6_r <= num_r;
      den6_r <= bf_mul(den_r, s2_r);
      sq5_r <= sq4_r;
    end
  end
  assign sq_r = sq5_r;

  // chain of cells: stage index 5 .. 5+N-1
  logic [65:0] rm_r [N+1];
  logic [32:0] rt_r [N+1];
  logic [63:0] rd_r [N+1];
  logic [64:0] dr_r [N+1];
  logic [63:0] dn_r [N+1];
  logic [31:0] dv_r [N+1];
  logic [32:0] dq_r [N+1];
  logic signed [ExpW-1:0] fe_r [N+1];
  logic        fz_r [N+1];

  always_comb begin
    rm_r[0] = '0; rt_r[0] = '0; rd_r[0] = sq_r;
    dr_r[0] = 65'(num6_r.m[31:1]); dn_r[0] = {num6_r.m[0], 63'd0};
    dv_r[0] = den6_r.m; dq_r[0] = '0;
    fe_r[0] = num6_r.e - ExpW'(32) - den6_r.e;
    fz_r[0] = (num6_r.m == '0) || (den6_r.m == '0);
  end

  // the sqrt path runs 32 steps; the 33rd cell passes the sqrt values through unchanged
  for (genvar i = 0; i < N; i++) begin : g_cell
    logic [65:0] rmo; logic [32:0] rto; logic [63:0] rdo;
    logic [64:0] dro; logic [63:0] dno; logic [32:0] dqo;
    logic [65:0] rm_q; logic [32:0] rt_q; logic [63:0] rd_q;
    logic [64:0] dr_q; logic [63:0] dn_q; logic [31:0] dv_q; logic [32:0] dq_q;
    logic signed [ExpW-1:0] fe_q; logic fz_q;
    tlsd_sqrt_cell u_cell (
      .rem_i(rm_r[i]), .root_i(rt_r[i]), .rad_i(rd_r[i]),
      .rem_o(rmo), .root_o(rto), .rad_o(rdo),
      .drem_i(dr_r[i]), .dnum_i(dn_r[i]), .dden_i(dv_r[i]), .dq_i(dq_r[i]),
      .drem_o(dro), .dnum_o(dno), .dq_o(dqo)
    );
    always_ff @(posedge clk) begin
      if (adv) begin
        if (i < SqrtSteps) begin
          rm_q <= rmo; rt_q <= rto; rd_q <= rdo;
        end else begin
          rm_q <= rm_r[i]; rt_q <= rt_r[i]; rd_q <= rd_r[i];
        end
        dr_q <= dro; dn_q <= dno; dv_q <= dv_r[i]; dq_q <= dqo;
        fe_q <= fe_r[i]; fz_q <= fz_r[i];
      end
    end
    assign rm_r[i+1] = rm_q; assign rt_r[i+1] = rt_q; assign rd_r[i+1] = rd_q;
    assign dr_r[i+1] = dr_q; assign dn_r[i+1] = dn_q; assign dv_r[i+1] = dv_q;
    assign dq_r[i+1] = dq_q; assign fe_r[i+1] = fe_q; assign fz_r[i+1] = fz_q;
  end

  // back stages
  bfl_t fac_r, kd_r, k_r, pe_r, pn_r;
  logic [31:0] mag_r;
  logic [31:0] aE, aN;
  logic [31:0] mag_q;
  logic [63:0] qe, qn;
  logic [31:0] oe_r, on_r;
  logic oerr_r, ofin_r, ov_r;

  always_comb begin
    aE = nd_r[N+7].se[31] ? 32'(-nd_r[N+7].se) : nd_r[N+7].se;
    aN = nd_r[N+7].sn[31] ? 32'(-nd_r[N+7].sn) : nd_r[N+7].sn;
    qe = bf_to_q16(pe_r);
    qn = bf_to_q16(pn_r);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      fac_r <= fz_r[N] ? bfl_t'('0) : bf_norm(64'(dq_r[N]), fe_r[N]);
      mag_r <= rt_r[N][31:0];
      kd_r  <= bf_mul(bf_norm(64'(drag_r), -ExpW'(24)), fac_r);
      mag_q <= mag_r;
      k_r   <= bf_mul(kd_r, bf_norm(64'(mag_q), -ExpW'(16)));
      pe_r  <= bf_mul(k_r, bf_norm(64'(aE), -ExpW'(16)));
      pn_r  <= bf_mul(k_r, bf_norm(64'(aN), -ExpW'(16)));
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      nd_r[0] <= nin;
      for (int j = 1; j < L; j++) nd_r[j] <= nd_r[j-1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
      ov_r <= 1'b0;
    end else begin
      if (adv) v_r <= {v_r[L-2:0], in_ch.valid};
      if (adv && v_r[L-1]) ov_r <= 1'b1;
      else if (out_ch.ready) ov_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && v_r[L-1]) begin
      oerr_r <= nd_r[L-1].err;
      ofin_r <= nd_r[L-1].fin;
      if (nd_r[L-1].err) begin
        oe_r <= nd_r[L-1].te;
        on_r <= nd_r[L-1].tn;
      end else begin
        oe_r <= nd_r[L-1].se[31] ? sat32(66'(nd_r[L-1].te) + $signed({2'b0, qe}))
                                 : sat32(66'(nd_r[L-1].te) - $signed({2'b0, qe}));
        on_r <= nd_r[L-1].sn[31] ? sat32(66'(nd_r[L-1].tn) + $signed({2'b0, qn}))
                                 : sat32(66'(nd_r[L-1].tn) - $signed({2'b0, qn}));
      end
    end
  end

  assign out_ch.valid = ov_r;
  assign out_ch.data  = {oe_r, on_r, oerr_r, ofin_r};
endmodule
`default_nettype wire
